[hdl/priority_class_wrr_queue_macros.svh]
// Assertion macros used by the priority class queue top level.
`ifndef PRIORITY_CLASS_WRR_QUEUE_MACROS_SVH
`define PRIORITY_CLASS_WRR_QUEUE_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define PCWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequence holds in the cycle after a trigger.
`define PCWQ_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pcwq_pkg.sv]
// Shared constants, types and codes of the priority class queue.
`timescale 1ns / 1ps
package pcwq_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;

  localparam int ID_W        = 16;
  localparam int REQ_CLASS_W = 5;
  localparam int OUT_CLASS_W = 4;
  localparam int STATUS_W    = 2;

  localparam int STORE_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int GNT_W   = $clog2(NUM_CLASSES + 1);
  localparam int RAM_DEPTH = NUM_CLASSES << PTR_W;

  // Stream widths; the data widths are padded to whole bytes.
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = STATUS_W;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Request code that selects the host default class.
  localparam logic signed [REQ_CLASS_W-1:0] CLASS_USE_HOST = -5'sd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef logic [CLS_W-1:0]  cls_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [FILL_W-1:0] fill_t;

  // Result fields that wait for the queue RAM read data.
  typedef struct packed {
    status_e                status;
    logic [OUT_CLASS_W-1:0] cls;
  } rsp_meta_t;

endpackage

[hdl/pcwq_ram.sv]
// Generic synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module pcwq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/priority_class_wrr_queue.sv]
// Top level of the weighted round robin scheduler over per-class ID queues.
`timescale 1ns / 1ps
// The block keeps one bounded FIFO of item IDs per priority class, all held in
// one RAM, and serves them by weighted round robin: class c may take up to c+1
// grants in a row before the turn passes on. A push (tuser 0) appends its ID
// to the queue of its class and answers with status pushed, or with status
// full and no change when that queue already holds its full depth. A pop
// (tuser 1) answers with the next scheduled ID and its class, or with status
// empty when every queue is empty. Each input transfer yields exactly one
// result transfer, in order. The block takes one item per cycle while the
// output is not stalled. The edge of the input transfer updates the
// pointers and reads or writes the RAM, and the edge on which stage one
// advances loads the RAM read data and the status into the output
// register. Queue pointers, fill counts and the round robin state live in
// flops and are updated in the cycle of the transfer, so a pop right behind
// a push already sees the new entry. A stalled output holds the result and
// the one item behind it, after which the input side is held off.
module priority_class_wrr_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // item_id [15:0], requested_class [20:16], has_host [21],
  // host_default_class [26:22], zero [31:27]
  input  logic [pcwq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // func [0]
  input  logic [pcwq_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_id [15:0], out_class [19:16], zero [23:20]
  output logic [pcwq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status [1:0]
  output logic [pcwq_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  import pcwq_pkg::*;

  `include "priority_class_wrr_queue_macros.svh"

  // Input fields.
  logic [ID_W-1:0]                in_id;
  logic signed [REQ_CLASS_W-1:0]  in_req_class;
  logic                           in_has_host;
  logic signed [REQ_CLASS_W-1:0]  in_host_class;
  logic                           in_func;

  assign in_id         = s_axis_tdata[15:0];
  assign in_req_class  = s_axis_tdata[20:16];
  assign in_has_host   = s_axis_tdata[21];
  assign in_host_class = s_axis_tdata[26:22];
  assign in_func       = s_axis_tuser[0];

  // Queue bookkeeping and round robin state.
  ptr_t              head_q [NUM_CLASSES];
  ptr_t              tail_q [NUM_CLASSES];
  fill_t             fill_q [NUM_CLASSES];
  cls_t              cur_q;
  logic [GNT_W-1:0]  grants_q;

  // Pipeline control: stage one waits for RAM data, the output stage holds
  // the result until the sink takes it.
  logic       s1_valid_q;
  rsp_meta_t  s1_meta_q;
  logic       out_valid_q;
  logic [ID_W-1:0]        out_id_q;
  logic [OUT_CLASS_W-1:0] out_class_q;
  status_e                out_status_q;

  logic s1_adv;
  logic in_acc;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Push class: take the host default for a request of -1 when a host is
  // present, then clamp into the range of implemented classes.
  logic signed [REQ_CLASS_W-1:0] eff_class;
  cls_t                          push_cls;

  always_comb begin
    eff_class = in_req_class;
    if (in_req_class == CLASS_USE_HOST && in_has_host) begin
      eff_class = in_host_class;
    end
    if (eff_class[REQ_CLASS_W-1]) begin
      push_cls = '0;
    end else if (eff_class[REQ_CLASS_W-2:0] > (REQ_CLASS_W-1)'(NUM_CLASSES - 1)) begin
      push_cls = CLS_W'(NUM_CLASSES - 1);
    end else begin
      push_cls = CLS_W'(eff_class[REQ_CLASS_W-2:0]);
    end
  end

  logic push_full;
  assign push_full = (fill_q[push_cls] == FILL_W'(QUEUE_DEPTH));

  // Pop scheduling. The current class is served while it has entries and
  // has not used up its grants. Otherwise the search rotates through the
  // following classes and ends on the current class itself.
  logic [NUM_CLASSES-1:0] nonempty;
  logic                   serve_cur;
  logic                   srch_hit;
  cls_t                   srch_cls;
  logic [CLS_W:0]         srch_idx;
  cls_t                   pop_cls;
  logic                   pop_hit;

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      nonempty[c] = (fill_q[c] != '0);
    end
    serve_cur = (grants_q <= GNT_W'(cur_q)) && nonempty[cur_q];
    srch_hit  = 1'b0;
    srch_cls  = cur_q;
    srch_idx  = '0;
    // Walk from the farthest class back so the nearest nonempty class wins.
    for (int k = NUM_CLASSES; k >= 1; k--) begin
      srch_idx = {1'b0, cur_q} + (CLS_W+1)'(k);
      if (srch_idx >= (CLS_W+1)'(NUM_CLASSES)) begin
        srch_idx = srch_idx - (CLS_W+1)'(NUM_CLASSES);
      end
      if (nonempty[srch_idx[CLS_W-1:0]]) begin
        srch_hit = 1'b1;
        srch_cls = srch_idx[CLS_W-1:0];
      end
    end
    pop_cls = serve_cur ? cur_q : srch_cls;
    pop_hit = serve_cur || srch_hit;
  end

  // Queue RAM: entry address is the class followed by the slot pointer.
  logic                    ram_we;
  logic                    ram_re;
  logic [CLS_W+PTR_W-1:0]  ram_waddr;
  logic [CLS_W+PTR_W-1:0]  ram_raddr;
  logic [STORE_W-1:0]      ram_wdata;
  logic [STORE_W-1:0]      ram_rdata;

  assign ram_we    = in_acc && (in_func == FUNC_PUSH) && !push_full;
  assign ram_re    = in_acc && (in_func == FUNC_POP) && pop_hit;
  assign ram_waddr = {push_cls, tail_q[push_cls]};
  assign ram_raddr = {pop_cls, head_q[pop_cls]};
  assign ram_wdata = STORE_W'(in_id);

  pcwq_ram #(
    .WIDTH (STORE_W),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic ptr_t wrap_next(input ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Result fields known in the transfer cycle.
  rsp_meta_t s1_meta_d;

  always_comb begin
    if (in_func == FUNC_PUSH) begin
      s1_meta_d.status = push_full ? ST_FULL : ST_PUSHED;
      s1_meta_d.cls    = OUT_CLASS_W'(push_cls);
    end else if (pop_hit) begin
      s1_meta_d.status = ST_POPPED;
      s1_meta_d.cls    = OUT_CLASS_W'(pop_cls);
    end else begin
      s1_meta_d.status = ST_EMPTY;
      s1_meta_d.cls    = '0;
    end
  end

  // Bookkeeping update, one queue touched per transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        fill_q[c] <= '0;
      end
      cur_q    <= '0;
      grants_q <= '0;
    end else if (in_acc) begin
      if (in_func == FUNC_PUSH) begin
        if (!push_full) begin
          tail_q[push_cls] <= wrap_next(tail_q[push_cls]);
          fill_q[push_cls] <= fill_q[push_cls] + FILL_W'(1);
        end
      end else if (serve_cur) begin
        head_q[cur_q] <= wrap_next(head_q[cur_q]);
        fill_q[cur_q] <= fill_q[cur_q] - FILL_W'(1);
        grants_q      <= grants_q + GNT_W'(1);
      end else if (srch_hit) begin
        head_q[srch_cls] <= wrap_next(head_q[srch_cls]);
        fill_q[srch_cls] <= fill_q[srch_cls] - FILL_W'(1);
        cur_q            <= srch_cls;
        grants_q         <= GNT_W'(1);
      end else begin
        // All queues empty: the turn goes all the way round and restarts.
        grants_q <= '0;
      end
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= in_acc;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_meta_q <= s1_meta_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_id_q     <= (s1_meta_q.status == ST_POPPED) ? ID_W'(ram_rdata) : '0;
      out_class_q  <= s1_meta_q.cls;
      out_status_q <= s1_meta_q.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - ID_W - OUT_CLASS_W)'(0), out_class_q, out_id_q};
  assign m_axis_tuser  = out_status_q;

  // Checks.
  `PCWQ_ASSERT(a_grants_bound, grants_q <= GNT_W'(cur_q) + GNT_W'(1),
               "grant count exceeds the weight of the current class")
  `PCWQ_ASSERT(a_cur_range, cur_q <= CLS_W'(NUM_CLASSES - 1),
               "current class out of range")
  `PCWQ_ASSERT_NEXT(a_rdata_hold, s1_valid_q && !s1_adv, $stable(ram_rdata),
                    "RAM read data changed under a stalled result")
  `PCWQ_ASSERT_NEXT(a_push_count, ram_we,
                    fill_q[$past(push_cls)] == $past(fill_q[push_cls]) + FILL_W'(1),
                    "accepted push did not raise the fill count")
  `PCWQ_ASSERT(a_read_nonempty, !ram_re || nonempty[pop_cls],
               "pop reads an empty queue")

endmodule
